@@ hw/rtl/accel_crash_rollover_detector_macros.svh @@
// assertion macros for the crash and rollover detector
// used by the top level; expects clk and rst_n in scope
`ifndef ACCEL_CRASH_ROLLOVER_DETECTOR_MACROS_SVH
`define ACCEL_CRASH_ROLLOVER_DETECTOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define ACRD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ACRD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/acrd_pkg.sv @@
// types, codes and threshold tables for the crash and rollover detector
// no dependencies; used by the top level
`default_nettype none

package acrd_pkg;

  // signed width wide enough for every limit and any sample width in range
  localparam int LIM_W = 17;
  typedef logic signed [LIM_W-1:0] lim_t;

  // roll test: x^2 * 2^ROLL_SHIFT > TAN2 * (y^2 + z^2)
  localparam int ROLL_SHIFT = 16;
  localparam int TAN2_W = 16;
  localparam logic [TAN2_W-1:0] ROLL_TAN2 = 16'd46077;

  localparam lim_t MOUNT_REV_LIMIT = -17'sd700;
  localparam lim_t BAD_X = 17'sd3000;
  localparam lim_t BAD_Y = 17'sd3000;
  localparam lim_t BAD_Z = 17'sd4000;

  // sensitivity levels
  localparam logic [1:0] LVL_LEAST = 2'd0;
  localparam logic [1:0] LVL_MID   = 2'd1;
  localparam logic [1:0] LVL_MOST  = 2'd2;
  localparam logic [1:0] LVL_RSVD  = 2'd3;

  // sample class codes
  localparam logic [2:0] CLS_EVAL    = 3'd0;
  localparam logic [2:0] CLS_SUSP    = 3'd1;
  localparam logic [2:0] CLS_INVALID = 3'd2;
  localparam logic [2:0] CLS_DUP     = 3'd3;
  localparam logic [2:0] CLS_MOUNT   = 3'd4;

  // axis codes
  localparam logic [2:0] AXIS_NONE = 3'd0;
  localparam logic [2:0] AXIS_X    = 3'd1;
  localparam logic [2:0] AXIS_Y    = 3'd2;
  localparam logic [2:0] AXIS_Z    = 3'd3;
  localparam logic [2:0] AXIS_ROLL = 3'd4;

  // alarm codes; one to four match the axis codes
  localparam logic [2:0] ALM_NONE    = 3'd0;
  localparam logic [2:0] ALM_SUSPEND = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_Z,
    ST_MUL_T,
    ST_MUL_R,
    ST_FIN
  } state_t;

  function automatic lim_t x_lim(input logic [1:0] lv);
    case (lv)
      LVL_LEAST: x_lim = 17'sd900;
      LVL_MID:   x_lim = 17'sd700;
      default:   x_lim = 17'sd500;
    endcase
  endfunction

  function automatic lim_t y_pos(input logic [1:0] lv);
    case (lv)
      LVL_LEAST: y_pos = 17'sd1200;
      LVL_MID:   y_pos = 17'sd800;
      default:   y_pos = 17'sd600;
    endcase
  endfunction

  function automatic lim_t y_neg(input logic [1:0] lv);
    case (lv)
      LVL_LEAST: y_neg = -17'sd400;
      default:   y_neg = -17'sd200;
    endcase
  endfunction

  function automatic lim_t z_pos(input logic [1:0] lv);
    case (lv)
      LVL_LEAST: z_pos = 17'sd2000;
      LVL_MID:   z_pos = 17'sd1600;
      default:   z_pos = 17'sd1400;
    endcase
  endfunction

  function automatic lim_t z_neg(input logic [1:0] lv);
    case (lv)
      LVL_LEAST: z_neg = -17'sd500;
      default:   z_neg = -17'sd300;
    endcase
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/acrd_mul.sv @@
// shared unsigned multiplier with registered product
// no package dependency; instantiated by the top level
`default_nettype none

module acrd_mul #(
  parameter int A_W = 29,
  parameter int B_W = 16
) (
  input  wire logic               clk,
  input  wire logic [A_W-1:0]     a,
  input  wire logic [B_W-1:0]     b,
  output logic      [A_W+B_W-1:0] p
);

  logic [A_W+B_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
  end

  assign p = p_r;

endmodule

`default_nettype wire

@@ hw/rtl/accel_crash_rollover_detector.sv @@
// top level of the accelerometer crash and rollover detector
// depends on acrd_pkg, acrd_mul and accel_crash_rollover_detector_macros.svh
//
// usage:
//   in_*  : one accelerometer sample per transaction (valid/ready)
//   out_* : one classification result per transaction (valid/ready)
//   cfg_* : sensitivity level write, taken on any cycle with cfg_wr_en high;
//           level three is ignored
// sequencing:
//   a sample runs through four passes of one shared multiplier
//   (x^2, y^2, z^2, then 46077 * (y^2 + z^2)), one add step and a final
//   compare step;
//   the result is registered in the final step, and a new sample is taken
//   only after the sequencer has returned to idle.
//   in_ready is high only while the sequencer is idle.
// stalls:
//   the result sits in an output register; a new sample may be taken while
//   it waits, and the sequencer holds in its final step until the register
//   is free.
// reset:
//   rst_n is synchronous active low; it clears the mount decision, the last
//   sample, the hit bits and sets sensitivity level 1.
`default_nettype none

`include "accel_crash_rollover_detector_macros.svh"

module accel_crash_rollover_detector #(
  parameter int SAMPLE_BITS = 14
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [1:0]                    cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_ignition_on,
  input  wire logic                          in_irq_crash,
  input  wire logic signed [SAMPLE_BITS-1:0] in_accel_x,
  input  wire logic signed [SAMPLE_BITS-1:0] in_accel_y,
  input  wire logic signed [SAMPLE_BITS-1:0] in_accel_z,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [2:0]                         out_sample_class,
  output logic [2:0]                         out_axis_exceeded,
  output logic [2:0]                         out_alarm,
  output logic                               out_mount_reversed
);

  localparam int SQ_W   = 2 * SAMPLE_BITS;
  localparam int SUM_W  = SQ_W + 1;
  localparam int MB_W   = acrd_pkg::TAN2_W;
  localparam int PROD_W = SUM_W + MB_W;
  localparam int EXT_W  = acrd_pkg::LIM_W - SAMPLE_BITS;

  acrd_pkg::state_t state_r, state_nxt;

  logic [1:0] sens_r;

  // captured sample
  logic                          ign_r, irq_r;
  logic signed [SAMPLE_BITS-1:0] x_r, y_r, z_r;

  // arithmetic pipeline registers and multiplier operands
  logic [SQ_W-1:0]  sqx_r;
  logic [SUM_W-1:0] syz_r;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0] mul_a;
  logic [MB_W-1:0]  mul_b;

  // detector state
  logic                          mount_known_r, mount_known_nxt;
  logic                          rev_r, rev_nxt;
  logic signed [SAMPLE_BITS-1:0] last_x_r, last_y_r, last_z_r;
  logic                          store_last;
  logic                          x_hits_r, y_hits_r, z_hits_r, roll_hits_r;
  logic                          x_hits_nxt, y_hits_nxt, z_hits_nxt, roll_hits_nxt;

  // output register
  logic       out_valid_r;
  logic [2:0] cls_r, axis_r, alarm_r;
  logic       rev_out_r;

  logic       fin_fire;
  logic       in_fire;
  logic [2:0] res_cls, res_axis, res_alarm;

  logic [SAMPLE_BITS-1:0] mag_x, mag_y, mag_z;
  acrd_pkg::lim_t         xe, ye, ze, zp, zn;
  logic [PROD_W-1:0]      roll_lhs;
  logic                   roll_over;

  assign in_fire = in_valid && in_ready;

  assign mag_x = x_r[SAMPLE_BITS-1] ? SAMPLE_BITS'(~x_r + 1'b1) : x_r;
  assign mag_y = y_r[SAMPLE_BITS-1] ? SAMPLE_BITS'(~y_r + 1'b1) : y_r;
  assign mag_z = z_r[SAMPLE_BITS-1] ? SAMPLE_BITS'(~z_r + 1'b1) : z_r;

  assign xe = {{EXT_W{x_r[SAMPLE_BITS-1]}}, x_r};
  assign ye = {{EXT_W{y_r[SAMPLE_BITS-1]}}, y_r};
  assign ze = {{EXT_W{z_r[SAMPLE_BITS-1]}}, z_r};

  acrd_mul #(
    .A_W (SUM_W),
    .B_W (MB_W)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      acrd_pkg::ST_IDLE:  if (in_valid) state_nxt = acrd_pkg::ST_MUL_X;
      acrd_pkg::ST_MUL_X: state_nxt = acrd_pkg::ST_MUL_Y;
      acrd_pkg::ST_MUL_Y: state_nxt = acrd_pkg::ST_MUL_Z;
      acrd_pkg::ST_MUL_Z: state_nxt = acrd_pkg::ST_MUL_T;
      acrd_pkg::ST_MUL_T: state_nxt = acrd_pkg::ST_MUL_R;
      acrd_pkg::ST_MUL_R: state_nxt = acrd_pkg::ST_FIN;
      acrd_pkg::ST_FIN:   if (!out_valid_r || out_ready) state_nxt = acrd_pkg::ST_IDLE;
      default:            state_nxt = acrd_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake and multiplier operand select
  always_comb begin
    in_ready = 1'b0;
    fin_fire = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    case (state_r)
      acrd_pkg::ST_IDLE: in_ready = 1'b1;
      acrd_pkg::ST_MUL_X: begin
        mul_a = SUM_W'(mag_x);
        mul_b = MB_W'(mag_x);
      end
      acrd_pkg::ST_MUL_Y: begin
        mul_a = SUM_W'(mag_y);
        mul_b = MB_W'(mag_y);
      end
      acrd_pkg::ST_MUL_Z: begin
        mul_a = SUM_W'(mag_z);
        mul_b = MB_W'(mag_z);
      end
      acrd_pkg::ST_MUL_R: begin
        mul_a = syz_r;
        mul_b = acrd_pkg::ROLL_TAN2;
      end
      acrd_pkg::ST_FIN: begin
        // keep the roll product steady while the result waits
        mul_a    = syz_r;
        mul_b    = acrd_pkg::ROLL_TAN2;
        fin_fire = !out_valid_r || out_ready;
      end
      default: ;
    endcase
  end

  // roll compare against the last product
  assign roll_lhs  = PROD_W'({sqx_r, {acrd_pkg::ROLL_SHIFT{1'b0}}});
  assign roll_over = roll_lhs > prod;

  // z window follows the mounting
  assign zp = rev_r ? -acrd_pkg::z_neg(sens_r) : acrd_pkg::z_pos(sens_r);
  assign zn = rev_r ? -acrd_pkg::z_pos(sens_r) : acrd_pkg::z_neg(sens_r);

  // classification and filter update
  always_comb begin
    res_cls         = acrd_pkg::CLS_EVAL;
    res_axis        = acrd_pkg::AXIS_NONE;
    res_alarm       = acrd_pkg::ALM_NONE;
    mount_known_nxt = mount_known_r;
    rev_nxt         = rev_r;
    store_last      = 1'b0;
    x_hits_nxt      = x_hits_r;
    y_hits_nxt      = y_hits_r;
    z_hits_nxt      = z_hits_r;
    roll_hits_nxt   = roll_hits_r;
    if (!mount_known_r) begin
      res_cls = acrd_pkg::CLS_MOUNT;
      if (z_r != '0) begin
        mount_known_nxt = 1'b1;
        rev_nxt         = ze < acrd_pkg::MOUNT_REV_LIMIT;
      end
    end else if (!ign_r) begin
      res_cls = acrd_pkg::CLS_SUSP;
      if (irq_r) res_alarm = acrd_pkg::ALM_SUSPEND;
    end else if (xe > acrd_pkg::BAD_X && ye > acrd_pkg::BAD_Y && ze > acrd_pkg::BAD_Z) begin
      res_cls = acrd_pkg::CLS_INVALID;
    end else if (x_r == last_x_r && y_r == last_y_r && z_r == last_z_r) begin
      res_cls = acrd_pkg::CLS_DUP;
    end else begin
      store_last = 1'b1;
      if (xe > acrd_pkg::x_lim(sens_r) || xe < -acrd_pkg::x_lim(sens_r)) begin
        res_axis   = acrd_pkg::AXIS_X;
        x_hits_nxt = !x_hits_r;
        if (x_hits_r) res_alarm = acrd_pkg::AXIS_X;
      end else if (ye > acrd_pkg::y_pos(sens_r) || ye < acrd_pkg::y_neg(sens_r)) begin
        res_axis   = acrd_pkg::AXIS_Y;
        y_hits_nxt = !y_hits_r;
        if (y_hits_r) res_alarm = acrd_pkg::AXIS_Y;
      end else if (ze > zp || ze < zn) begin
        res_axis   = acrd_pkg::AXIS_Z;
        z_hits_nxt = !z_hits_r;
        if (z_hits_r) res_alarm = acrd_pkg::AXIS_Z;
      end else if (roll_over) begin
        res_axis      = acrd_pkg::AXIS_ROLL;
        roll_hits_nxt = !roll_hits_r;
        if (roll_hits_r) res_alarm = acrd_pkg::AXIS_ROLL;
      end else begin
        x_hits_nxt    = 1'b0;
        y_hits_nxt    = 1'b0;
        z_hits_nxt    = 1'b0;
        roll_hits_nxt = 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= acrd_pkg::ST_IDLE;
      sens_r        <= acrd_pkg::LVL_MID;
      mount_known_r <= 1'b0;
      rev_r         <= 1'b0;
      last_x_r      <= '0;
      last_y_r      <= '0;
      last_z_r      <= '0;
      x_hits_r      <= 1'b0;
      y_hits_r      <= 1'b0;
      z_hits_r      <= 1'b0;
      roll_hits_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en && cfg_wr_data != acrd_pkg::LVL_RSVD) sens_r <= cfg_wr_data;
      if (fin_fire) begin
        mount_known_r <= mount_known_nxt;
        rev_r         <= rev_nxt;
        x_hits_r      <= x_hits_nxt;
        y_hits_r      <= y_hits_nxt;
        z_hits_r      <= z_hits_nxt;
        roll_hits_r   <= roll_hits_nxt;
        if (store_last) begin
          last_x_r <= x_r;
          last_y_r <= y_r;
          last_z_r <= z_r;
        end
      end
      if (fin_fire) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ign_r <= in_ignition_on;
      irq_r <= in_irq_crash;
      x_r   <= in_accel_x;
      y_r   <= in_accel_y;
      z_r   <= in_accel_z;
    end
    case (state_r)
      acrd_pkg::ST_MUL_Y: sqx_r <= prod[SQ_W-1:0];
      acrd_pkg::ST_MUL_Z: syz_r <= SUM_W'(prod[SQ_W-1:0]);
      acrd_pkg::ST_MUL_T: syz_r <= syz_r + SUM_W'(prod[SQ_W-1:0]);
      default: ;
    endcase
    if (fin_fire) begin
      cls_r     <= res_cls;
      axis_r    <= res_axis;
      alarm_r   <= res_alarm;
      rev_out_r <= rev_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sample_class   = cls_r;
  assign out_axis_exceeded  = axis_r;
  assign out_alarm          = alarm_r;
  assign out_mount_reversed = rev_out_r;

  `ACRD_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  `ACRD_ASSERT_IMP(a_axis_only_eval, out_valid, out_axis_exceeded == acrd_pkg::AXIS_NONE || out_sample_class == acrd_pkg::CLS_EVAL, "axis set on non-evaluated sample")
  `ACRD_ASSERT_IMP(a_alarm_source, out_valid && out_alarm != acrd_pkg::ALM_NONE, (out_alarm == acrd_pkg::ALM_SUSPEND && out_sample_class == acrd_pkg::CLS_SUSP) || (out_sample_class == acrd_pkg::CLS_EVAL && out_alarm == out_axis_exceeded), "alarm without matching cause")
  `ACRD_ASSERT_NXT(a_fin_holds, state_r == acrd_pkg::ST_FIN && out_valid_r && !out_ready, state_r == acrd_pkg::ST_FIN, "result step left while output full")

endmodule

`default_nettype wire

@@ tb/accel_crash_rollover_detector_tb.sv @@
// self-checking testbench for the accelerometer crash and rollover detector
// depends on acrd_pkg and the accel_crash_rollover_detector top level
// a scoreboard class predicts each verdict; tasks drive samples and config
`timescale 1ns / 100ps

module accel_crash_rollover_detector_tb;

  localparam int SAMPLE_W       = 14;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int PHASE_ITEMS    = 240;
  localparam int NUM_PHASES     = 8;

  // threshold tables per sensitivity level
  localparam int X_LIM[3] = '{900, 700, 500};
  localparam int Y_POS[3] = '{1200, 800, 600};
  localparam int Y_NEG[3] = '{-400, -200, -200};
  localparam int Z_POS[3] = '{2000, 1600, 1400};
  localparam int Z_NEG[3] = '{-500, -300, -300};

  // values that sit on or next to a decision boundary
  localparam int EDGE_VALS[24] = '{
    900, -900, 700, -700, 500, -500, 1200, 800, 600, -400, -200, 2000,
    1600, 1400, -300, 300, -1400, -1600, -2000, 3000, 4000, -701, 8191, -8192
  };

  typedef logic signed [SAMPLE_W-1:0] sample_word_t;

  typedef struct {
    bit           ign;
    bit           irq;
    sample_word_t x;
    sample_word_t y;
    sample_word_t z;
  } sample_t;

  typedef struct {
    logic [2:0] cls;
    logic [2:0] axis;
    logic [2:0] alarm;
    logic       rev;
  } verdict_t;

  class crash_scoreboard;
    verdict_t   predicted_verdicts[$];
    logic [1:0] level;
    bit         mount_known;
    bit         reversed;
    int         last_x, last_y, last_z;
    bit         hits[1:4];
    int         mismatches;

    function new();
      level       = acrd_pkg::LVL_MID;
      mount_known = 0;
      reversed    = 0;
      last_x      = 0;
      last_y      = 0;
      last_z      = 0;
      mismatches  = 0;
      foreach (hits[i]) hits[i] = 0;
    endfunction

    function void write_level(logic [1:0] v);
      // reserved level leaves the table selection alone
      if (v != acrd_pkg::LVL_RSVD) level = v;
    endfunction

    // two-hit filter: fire on the second consecutive failure
    function bit filter_hit(logic [2:0] axis);
      if (hits[axis]) begin
        hits[axis] = 0;
        return 1;
      end
      hits[axis] = 1;
      return 0;
    endfunction

    function void classify_sample(sample_t s);
      verdict_t v;
      int       x, y, z, zp, zn;
      longint   roll_lhs, roll_rhs;
      bit       roll;
      x = int'(s.x);
      y = int'(s.y);
      z = int'(s.z);
      v.cls   = acrd_pkg::CLS_EVAL;
      v.axis  = acrd_pkg::AXIS_NONE;
      v.alarm = acrd_pkg::ALM_NONE;
      if (!mount_known) begin
        v.cls = acrd_pkg::CLS_MOUNT;
        if (z != 0) begin
          mount_known = 1;
          reversed    = (z < acrd_pkg::MOUNT_REV_LIMIT);
        end
      end else if (!s.ign) begin
        v.cls = acrd_pkg::CLS_SUSP;
        if (s.irq) v.alarm = acrd_pkg::ALM_SUSPEND;
      end else if (x > acrd_pkg::BAD_X && y > acrd_pkg::BAD_Y && z > acrd_pkg::BAD_Z) begin
        v.cls = acrd_pkg::CLS_INVALID;
      end else if (x == last_x && y == last_y && z == last_z) begin
        v.cls = acrd_pkg::CLS_DUP;
      end else begin
        zp = reversed ? -Z_NEG[level] : Z_POS[level];
        zn = reversed ? -Z_POS[level] : Z_NEG[level];
        roll_lhs = longint'(x * x) << acrd_pkg::ROLL_SHIFT;
        roll_rhs = longint'(acrd_pkg::ROLL_TAN2) * longint'(y * y + z * z);
        roll = (roll_lhs > roll_rhs);
        last_x = x;
        last_y = y;
        last_z = z;
        if (x > X_LIM[level] || x < -X_LIM[level]) begin
          v.axis = acrd_pkg::AXIS_X;
          if (filter_hit(acrd_pkg::AXIS_X)) v.alarm = acrd_pkg::AXIS_X;
        end else if (y > Y_POS[level] || y < Y_NEG[level]) begin
          v.axis = acrd_pkg::AXIS_Y;
          if (filter_hit(acrd_pkg::AXIS_Y)) v.alarm = acrd_pkg::AXIS_Y;
        end else if (z > zp || z < zn) begin
          v.axis = acrd_pkg::AXIS_Z;
          if (filter_hit(acrd_pkg::AXIS_Z)) v.alarm = acrd_pkg::AXIS_Z;
        end else if (roll) begin
          v.axis = acrd_pkg::AXIS_ROLL;
          if (filter_hit(acrd_pkg::AXIS_ROLL)) v.alarm = acrd_pkg::AXIS_ROLL;
        end else begin
          foreach (hits[i]) hits[i] = 0;
        end
      end
      v.rev = reversed;
      predicted_verdicts.push_back(v);
    endfunction

    function void check_verdict(logic [2:0] cls, logic [2:0] axis, logic [2:0] alarm,
                                logic rev);
      verdict_t want;
      if (predicted_verdicts.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result with no sample pending: class %0d axis %0d alarm %0d rev %0d",
                   $realtime, cls, axis, alarm, rev);
        mismatches++;
        return;
      end
      want = predicted_verdicts.pop_front();
      if (cls !== want.cls || axis !== want.axis || alarm !== want.alarm ||
          rev !== want.rev) begin
        if (mismatches < 10)
          $display("%0t: verdict mismatch: class %0d/%0d axis %0d/%0d alarm %0d/%0d rev %0d/%0d",
                   $realtime, want.cls, cls, want.axis, axis, want.alarm, alarm,
                   want.rev, rev);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [1:0]          cfg_wr_data;
  logic                in_valid;
  logic                in_ready;
  logic                in_ignition_on;
  logic                in_irq_crash;
  sample_word_t        in_accel_x;
  sample_word_t        in_accel_y;
  sample_word_t        in_accel_z;
  logic                out_valid;
  logic                out_ready;
  logic [2:0]          out_sample_class;
  logic [2:0]          out_axis_exceeded;
  logic [2:0]          out_alarm;
  logic                out_mount_reversed;

  crash_scoreboard sb;
  int              send_count;
  bit              send_quiet;
  sample_t         prev_sample;
  int              prev_kind;
  int              stalled_cycles;

  accel_crash_rollover_detector #(
    .SAMPLE_BITS(SAMPLE_W)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_ignition_on    (in_ignition_on),
    .in_irq_crash      (in_irq_crash),
    .in_accel_x        (in_accel_x),
    .in_accel_y        (in_accel_y),
    .in_accel_z        (in_accel_z),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sample_class  (out_sample_class),
    .out_axis_exceeded (out_axis_exceeded),
    .out_alarm         (out_alarm),
    .out_mount_reversed(out_mount_reversed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic sample_t mk_sample(bit ign, bit irq, int x, int y, int z);
    sample_t s;
    s.ign = ign;
    s.irq = irq;
    s.x   = sample_word_t'(x);
    s.y   = sample_word_t'(y);
    s.z   = sample_word_t'(z);
    return s;
  endfunction

  function automatic int rand_span(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int near_limit();
    if ($urandom_range(0, 1))
      return rand_span(-150, 150);
    return EDGE_VALS[$urandom_range(0, 23)] + rand_span(-1, 1);
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int      kind;
    // kinds tend to repeat so the two-hit filters get consecutive failures
    kind = ($urandom_range(0, 1) != 0) ? prev_kind : int'($urandom_range(0, 99));
    prev_kind = kind;
    s.ign = 1'b1;
    s.irq = 1'($urandom_range(0, 1));
    if (kind < 8) begin
      s.ign = 1'b0;
      s.x = sample_word_t'($urandom);
      s.y = sample_word_t'($urandom);
      s.z = sample_word_t'($urandom);
    end else if (kind < 13) begin
      s.x = sample_word_t'(rand_span(3001, 8191));
      s.y = sample_word_t'(rand_span(3001, 8191));
      s.z = sample_word_t'(rand_span(4001, 8191));
    end else if (kind < 23) begin
      s.x = prev_sample.x;
      s.y = prev_sample.y;
      s.z = prev_sample.z;
    end else if (kind < 45) begin
      s.x = sample_word_t'(rand_span(-400, 400));
      s.y = sample_word_t'(rand_span(-150, 500));
      s.z = sample_word_t'(rand_span(-250, 250));
    end else if (kind < 65) begin
      s.x = sample_word_t'(near_limit());
      s.y = sample_word_t'(near_limit());
      s.z = sample_word_t'(near_limit());
    end else if (kind < 80) begin
      // large x against small y and z pushes the roll angle over 40 degrees
      s.x = sample_word_t'(rand_span(-900, 900));
      s.y = sample_word_t'(rand_span(-300, 300));
      s.z = sample_word_t'(rand_span(-300, 300));
    end else begin
      s.ign = $urandom_range(0, 7) != 0;
      s.x = sample_word_t'($urandom);
      s.y = sample_word_t'($urandom);
      s.z = sample_word_t'($urandom);
    end
    prev_sample = s;
    return s;
  endfunction

  task automatic send_sample(input sample_t s);
    int gap;
    if (send_count % 50 == 0) send_quiet = ($urandom_range(0, 3) == 0);
    send_count++;
    gap = send_quiet ? 0 : int'($urandom_range(0, 11));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ignition_on <= s.ign;
    in_irq_crash   <= s.irq;
    in_accel_x     <= s.x;
    in_accel_y     <= s.y;
    in_accel_z     <= s.z;
    in_valid       <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.classify_sample(s);
  endtask

  // wait until every pending verdict has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.predicted_verdicts.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_level(input logic [1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.write_level(v);
  endtask

  initial begin : stimulus
    logic [1:0] phase_levels[NUM_PHASES];
    int         mount_z;
    sb = new();
    send_count  = 0;
    send_quiet  = 0;
    prev_kind   = 50;
    prev_sample = mk_sample(1, 0, 0, 0, 0);
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= acrd_pkg::LVL_MID;
    in_valid       <= 1'b0;
    in_ignition_on <= 1'b0;
    in_irq_crash   <= 1'b0;
    in_accel_x     <= '0;
    in_accel_y     <= '0;
    in_accel_z     <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // mounting: zero z leaves it open, ignition and irq are not looked at yet
    case ($urandom_range(0, 2))
      0:       mount_z = -701;
      1:       mount_z = -700;
      default: mount_z = 3;
    endcase
    send_sample(mk_sample(0, 1, 8191, -8192, 0));
    send_sample(mk_sample(1, 0, 0, 0, 0));
    send_sample(mk_sample(1, 1, 0, 0, mount_z));
    // suspend, with and without the irq flag
    send_sample(mk_sample(0, 0, 100, 100, 100));
    send_sample(mk_sample(0, 1, -8192, 8191, -8192));
    // all-zero sample matches the reset value of the last sample
    send_sample(mk_sample(1, 0, 0, 0, 0));
    send_sample(mk_sample(1, 1, 3001, 3001, 4001));
    send_sample(mk_sample(1, 0, 3000, 3001, 4001));
    send_sample(mk_sample(1, 0, 8191, 8191, 8191));
    send_sample(mk_sample(1, 0, -8192, 0, 0));
    send_sample(mk_sample(1, 0, -8192, 0, 0));
    send_sample(mk_sample(1, 0, 0, 801, 0));
    send_sample(mk_sample(1, 0, 0, -8192, 0));
    send_sample(mk_sample(1, 0, 0, 0, 8191));
    send_sample(mk_sample(1, 0, 0, 0, -8192));
    send_sample(mk_sample(1, 0, 600, 100, 100));
    // nonzero x with zero y and z is over the roll limit
    send_sample(mk_sample(1, 0, -600, 0, 0));
    send_sample(mk_sample(1, 0, 1, 1, 1));
    send_sample(mk_sample(1, 0, 0, 0, 0));
    send_sample(mk_sample(1, 0, 700, 800, -300));
    send_sample(mk_sample(1, 0, 8191, 8191, 0));
    send_sample(mk_sample(1, 1, -8192, -8192, -8192));

    phase_levels = '{acrd_pkg::LVL_LEAST, acrd_pkg::LVL_MOST, acrd_pkg::LVL_RSVD,
                     acrd_pkg::LVL_MID, acrd_pkg::LVL_LEAST, acrd_pkg::LVL_RSVD,
                     acrd_pkg::LVL_MOST, acrd_pkg::LVL_LEAST};
    phase_levels[NUM_PHASES-1] = 2'($urandom_range(0, 3));
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_level(phase_levels[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) send_sample(random_sample());
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.predicted_verdicts.size() == 0) begin
      $display("[accel_crash_rollover_detector] OK");
    end else begin
      $display("[accel_crash_rollover_detector] ERROR");
    end
    $finish;
  end

  initial begin : result_sink
    int stall;
    bit quiet;
    int n;
    out_ready <= 1'b0;
    quiet = 0;
    n     = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (n % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      n++;
      stall = quiet ? 0 : int'($urandom_range(0, 11));
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_verdict(out_sample_class, out_axis_exceeded, out_alarm, out_mount_reversed);
  end

  // watchdog on cycles without any transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      stalled_cycles = 0;
    else
      stalled_cycles = stalled_cycles + 1;
    if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("[accel_crash_rollover_detector] ERROR");
      $finish;
    end
  end

endmodule
